[rtl/cbe_pkg.sv]
// Shared types, constants and command encodings for the cubic Bezier easing evaluator.
package cbe_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int QI           = 24;
    localparam int NEWTON_STEPS = 6;
    localparam int BISECT_STEPS = 16;
    localparam int QUO_BITS     = 26;

    localparam int CW   = 36;           // coefficient and accumulator width
    localparam int TW   = 28;           // parameter t register width
    localparam int TEW  = 26;           // t width used by the multiplier
    localparam int PW   = CW + TEW;     // product width
    localparam int OW   = 20;           // output width
    localparam int PINW = 18;           // progress width
    localparam int XW   = 17;           // control x width
    localparam int YW   = 20;           // control y width

    localparam int EPS_NEWTON = 17;
    localparam int EPS_BISECT = 168;
    localparam int OUT_MAX    = 262144;

    localparam int NCNT_W = $clog2(NEWTON_STEPS);
    localparam int BCNT_W = $clog2(BISECT_STEPS);
    localparam int DCNT_W = $clog2(QUO_BITS);

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SET,
        OP_MUL,
        OP_ADD,
        OP_SAVEX,
        OP_DIVINIT,
        OP_DIVSTEP,
        OP_NUPD,
        OP_BINIT,
        OP_BUPD,
        OP_FIN
    } op_t;

    typedef enum logic [1:0] {
        POLY_X,
        POLY_D,
        POLY_Y
    } poly_t;

    typedef enum logic [2:0] {
        ADD_ZERO,
        ADD_BX,
        ADD_2BX,
        ADD_CX,
        ADD_BY,
        ADD_CY
    } addend_t;

    typedef struct packed {
        op_t     op;
        poly_t   poly;
        addend_t addend;
    } cmd_t;

    typedef struct packed {
        logic special;
        logic d_small;
        logic err_small;
        logic t_out;
        logic bis_close;
    } status_t;

    typedef enum logic [1:0] {
        REG_CTRL1_X = 2'd0,
        REG_CTRL1_Y = 2'd1,
        REG_CTRL2_X = 2'd2,
        REG_CTRL2_Y = 2'd3
    } reg_idx_t;

endpackage

[rtl/cbe_datapath.sv]
// Datapath: coefficients, Horner multiply-accumulate, Newton divider, bisection bounds.
module cbe_datapath
    import cbe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    input  logic [PINW-1:0]        progress_in,
    input  logic [XW-1:0]          ctrl1_x,
    input  logic signed [YW-1:0]   ctrl1_y,
    input  logic [XW-1:0]          ctrl2_x,
    input  logic signed [YW-1:0]   ctrl2_y,
    output status_t                status,
    output logic                   result_valid,
    output logic signed [OW-1:0]   eased_value
);

    localparam logic signed [CW-1:0] ONE_C = CW'(1) <<< QI;
    localparam logic signed [TW-1:0] ONE_T = TW'(1) <<< QI;
    localparam logic [XW-1:0]        ONE_X = XW'(1) << FRAC_BITS;
    localparam int                   SH    = QI - FRAC_BITS;

    logic signed [CW-1:0] ax_reg, bx_reg, cx_reg, ay_reg, by_reg, cy_reg;
    logic signed [CW-1:0] acc_reg, x_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [TW-1:0] t_reg, pq_reg;
    logic [QI:0]          t0_reg, t1_reg;
    logic [CW-1:0]        rem_reg, den_reg;
    logic [QUO_BITS-1:0]  nlow_reg, quo_reg;
    logic                 qneg_reg, ovf_reg, special_reg;
    logic signed [OW-1:0] spec_val_reg;
    logic signed [OW-1:0] result_reg;
    logic                 valid_reg;

    // Load-time arithmetic.
    logic signed [PINW-1:0] p_s;
    logic [XW-1:0]          x1c, x2c;
    logic signed [CW-1:0]   x1q, x2q, y1q, y2q;
    logic signed [CW-1:0]   cx_n, bx_n, ax_n, cy_n, by_n, ay_n;
    logic                   p_le0, p_ge1, ident;

    assign p_s = signed'(progress_in);
    assign x1c = (ctrl1_x > ONE_X) ? ONE_X : ctrl1_x;
    assign x2c = (ctrl2_x > ONE_X) ? ONE_X : ctrl2_x;
    assign x1q = signed'(CW'(x1c)) <<< SH;
    assign x2q = signed'(CW'(x2c)) <<< SH;
    assign y1q = CW'(ctrl1_y) <<< SH;
    assign y2q = CW'(ctrl2_y) <<< SH;
    assign cx_n = 3 * x1q;
    assign bx_n = 3 * (x2q - x1q) - cx_n;
    assign ax_n = ONE_C - cx_n - bx_n;
    assign cy_n = 3 * y1q;
    assign by_n = 3 * (y2q - y1q) - cy_n;
    assign ay_n = ONE_C - cy_n - by_n;
    assign p_le0 = (p_s <= 0);
    assign p_ge1 = (p_s >= signed'(PINW'(ONE_X)));
    assign ident = (signed'((YW+1)'(x1c)) == (YW+1)'(ctrl1_y))
                && (signed'((YW+1)'(x2c)) == (YW+1)'(ctrl2_y));

    // Horner step.
    logic signed [TEW-1:0] t_eval;
    logic signed [PW-1:0]  prod_n, rsum;
    logic signed [CW-1:0]  rnd, addend, init_v;

    assign t_eval = t_reg[TEW-1:0];
    assign prod_n = PW'(acc_reg) * PW'(t_eval);
    assign rsum   = prod_reg + (PW'(1) <<< (QI - 1));
    assign rnd    = CW'(rsum >>> QI);

    always_comb
    begin
        unique case (cmd.addend)
            ADD_ZERO: addend = '0;
            ADD_BX:   addend = bx_reg;
            ADD_2BX:  addend = bx_reg <<< 1;
            ADD_CX:   addend = cx_reg;
            ADD_BY:   addend = by_reg;
            ADD_CY:   addend = cy_reg;
            default:  addend = '0;
        endcase
    end

    always_comb
    begin
        unique case (cmd.poly)
            POLY_X:  init_v = ax_reg;
            POLY_D:  init_v = 3 * ax_reg;
            POLY_Y:  init_v = ay_reg;
            default: init_v = ax_reg;
        endcase
    end

    // Newton error and divider.
    logic signed [CW-1:0] err;
    logic [CW-1:0]        err_abs, d_abs;
    logic [CW+1:0]        d_x4;
    logic [CW:0]          rem2;
    logic                 qbit;
    logic signed [TW-1:0] q_s, t_upd;

    assign err     = x_reg - CW'(pq_reg);
    assign err_abs = err[CW-1] ? CW'(-err) : CW'(err);
    assign d_abs   = acc_reg[CW-1] ? CW'(-acc_reg) : CW'(acc_reg);
    assign d_x4    = {d_abs, 2'b00};
    assign rem2    = {rem_reg, nlow_reg[QUO_BITS-1]};
    assign qbit    = (rem2 >= (CW+1)'(den_reg));
    assign q_s     = signed'(TW'(quo_reg));
    assign t_upd   = qneg_reg ? (t_reg + q_s) : (t_reg - q_s);

    // Bisection.
    logic signed [CW-1:0] xdiff;
    logic [CW-1:0]        xdiff_abs;
    logic [QI:0]          t0_n, t1_n;
    logic [QI+1:0]        tsum;

    assign xdiff     = acc_reg - CW'(pq_reg);
    assign xdiff_abs = xdiff[CW-1] ? CW'(-xdiff) : CW'(xdiff);
    assign t0_n      = (CW'(pq_reg) > acc_reg) ? t_reg[QI:0] : t0_reg;
    assign t1_n      = (CW'(pq_reg) > acc_reg) ? t1_reg : t_reg[QI:0];
    assign tsum      = (QI+2)'(t0_n) + (QI+2)'(t1_n);

    // Final rounding and saturation.
    logic signed [CW-1:0] yr;
    logic signed [OW-1:0] ysat;

    assign yr = (acc_reg + (CW'(1) <<< (SH - 1))) >>> SH;

    always_comb
    begin
        priority if (yr > CW'(OUT_MAX))
            ysat = OW'(OUT_MAX);
        else if (yr < -CW'(OUT_MAX))
            ysat = -OW'(OUT_MAX);
        else
            ysat = yr[OW-1:0];
    end

    assign status.special   = special_reg;
    assign status.d_small   = (d_abs < CW'(EPS_NEWTON));
    assign status.err_small = (err_abs < CW'(EPS_NEWTON));
    assign status.t_out     = (t_reg < 0) || (t_reg > ONE_T);
    assign status.bis_close = (xdiff_abs < CW'(EPS_BISECT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= (cmd.op == OP_FIN);
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                ax_reg      <= ax_n;
                bx_reg      <= bx_n;
                cx_reg      <= cx_n;
                ay_reg      <= ay_n;
                by_reg      <= by_n;
                cy_reg      <= cy_n;
                pq_reg      <= TW'(p_s) <<< SH;
                t_reg       <= TW'(p_s) <<< SH;
                special_reg <= p_le0 || p_ge1 || ident;
                if (p_le0)
                    spec_val_reg <= '0;
                else if (p_ge1)
                    spec_val_reg <= OW'(ONE_X);
                else
                    spec_val_reg <= OW'(p_s);
            end
            OP_SET:   acc_reg  <= init_v;
            OP_MUL:   prod_reg <= prod_n;
            OP_ADD:   acc_reg  <= rnd + addend;
            OP_SAVEX: x_reg    <= acc_reg;
            OP_DIVINIT:
            begin
                den_reg  <= d_abs;
                rem_reg  <= CW'(err_abs >> 2);
                nlow_reg <= {err_abs[1:0], {(QUO_BITS-2){1'b0}}};
                quo_reg  <= '0;
                qneg_reg <= err[CW-1] ^ acc_reg[CW-1];
                ovf_reg  <= ((CW+2)'(err_abs) >= d_x4);
            end
            OP_DIVSTEP:
            begin
                rem_reg  <= qbit ? CW'(rem2 - (CW+1)'(den_reg)) : CW'(rem2);
                nlow_reg <= nlow_reg << 1;
                quo_reg  <= {quo_reg[QUO_BITS-2:0], qbit};
            end
            OP_NUPD:  t_reg <= ovf_reg ? -TW'(1) : t_upd;
            OP_BINIT:
            begin
                t_reg  <= pq_reg;
                t0_reg <= '0;
                t1_reg <= ONE_T[QI:0];
            end
            OP_BUPD:
            begin
                t0_reg <= t0_n;
                t1_reg <= t1_n;
                t_reg  <= TW'(tsum[QI+1:1]);
            end
            OP_FIN:   result_reg <= special_reg ? spec_val_reg : ysat;
            default:  ;
        endcase
    end

    assign result_valid = valid_reg;
    assign eased_value  = result_reg;

endmodule

[rtl/cbe_ctrl.sv]
// Controller: sequences Horner evaluation, Newton iterations, division and bisection.
module cbe_ctrl
    import cbe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output logic    busy,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPCHK,
        S_HSET,
        S_HMUL,
        S_HADD,
        S_SAVEX,
        S_NCHK,
        S_DIV,
        S_NUPD,
        S_NNEXT,
        S_BINIT,
        S_BCHK,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        P_NX,
        P_ND,
        P_BX,
        P_Y
    } purpose_t;

    state_t              state_reg, state_next;
    purpose_t            purp_reg, purp_next;
    logic [1:0]          hstep_reg, hstep_next;
    logic [NCNT_W-1:0]   ncnt_reg, ncnt_next;
    logic [BCNT_W-1:0]   bcnt_reg, bcnt_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;
    poly_t               poly;
    logic                hlast;

    always_comb
    begin
        unique case (purp_reg)
            P_ND:    poly = POLY_D;
            P_Y:     poly = POLY_Y;
            default: poly = POLY_X;
        endcase
    end

    assign hlast = (purp_reg == P_ND) ? (hstep_reg == 2'd1) : (hstep_reg == 2'd2);

    always_comb
    begin
        state_next = state_reg;
        purp_next  = purp_reg;
        hstep_next = hstep_reg;
        ncnt_next  = ncnt_reg;
        bcnt_next  = bcnt_reg;
        dcnt_next  = dcnt_reg;
        cmd.op     = OP_NOP;
        cmd.poly   = poly;
        cmd.addend = ADD_ZERO;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_SPCHK;
                end
            end
            S_SPCHK:
            begin
                ncnt_next = '0;
                purp_next = P_NX;
                state_next = status.special ? S_FIN : S_HSET;
            end
            S_HSET:
            begin
                cmd.op     = OP_SET;
                hstep_next = '0;
                state_next = S_HMUL;
            end
            S_HMUL:
            begin
                cmd.op     = OP_MUL;
                state_next = S_HADD;
            end
            S_HADD:
            begin
                cmd.op = OP_ADD;
                unique case (hstep_reg)
                    2'd0:
                        if (purp_reg == P_Y)
                            cmd.addend = ADD_BY;
                        else if (purp_reg == P_ND)
                            cmd.addend = ADD_2BX;
                        else
                            cmd.addend = ADD_BX;
                    2'd1:
                        cmd.addend = (purp_reg == P_Y) ? ADD_CY : ADD_CX;
                    default:
                        cmd.addend = ADD_ZERO;
                endcase
                if (hlast)
                begin
                    unique case (purp_reg)
                        P_NX:    state_next = S_SAVEX;
                        P_ND:    state_next = S_NCHK;
                        P_BX:    state_next = S_BCHK;
                        default: state_next = S_FIN;
                    endcase
                end
                else
                begin
                    hstep_next = hstep_reg + 2'd1;
                    state_next = S_HMUL;
                end
            end
            S_SAVEX:
            begin
                cmd.op     = OP_SAVEX;
                purp_next  = P_ND;
                state_next = S_HSET;
            end
            S_NCHK:
            begin
                if (status.d_small || status.err_small)
                begin
                    purp_next  = P_Y;
                    state_next = S_HSET;
                end
                else
                begin
                    cmd.op     = OP_DIVINIT;
                    dcnt_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.op    = OP_DIVSTEP;
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(QUO_BITS - 1))
                    state_next = S_NUPD;
            end
            S_NUPD:
            begin
                cmd.op     = OP_NUPD;
                state_next = S_NNEXT;
            end
            S_NNEXT:
            begin
                if (status.t_out)
                    state_next = S_BINIT;
                else if (ncnt_reg == NCNT_W'(NEWTON_STEPS - 1))
                begin
                    purp_next  = P_Y;
                    state_next = S_HSET;
                end
                else
                begin
                    ncnt_next  = ncnt_reg + NCNT_W'(1);
                    purp_next  = P_NX;
                    state_next = S_HSET;
                end
            end
            S_BINIT:
            begin
                cmd.op     = OP_BINIT;
                bcnt_next  = '0;
                purp_next  = P_BX;
                state_next = S_HSET;
            end
            S_BCHK:
            begin
                if (status.bis_close)
                begin
                    purp_next  = P_Y;
                    state_next = S_HSET;
                end
                else
                begin
                    cmd.op    = OP_BUPD;
                    bcnt_next = bcnt_reg + BCNT_W'(1);
                    if (bcnt_reg == BCNT_W'(BISECT_STEPS - 1))
                        purp_next = P_Y;
                    else
                        purp_next = P_BX;
                    state_next = S_HSET;
                end
            end
            S_FIN:
            begin
                cmd.op     = OP_FIN;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            purp_reg  <= P_NX;
            hstep_reg <= '0;
            ncnt_reg  <= '0;
            bcnt_reg  <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            purp_reg  <= purp_next;
            hstep_reg <= hstep_next;
            ncnt_reg  <= ncnt_next;
            bcnt_reg  <= bcnt_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[rtl/cubic_bezier_easing_eval.sv]
// Top level of the cubic Bezier easing evaluator: configuration registers and wiring.
//
// This block evaluates a CSS-style cubic-bezier timing curve: for a progress
// value it finds t with x(t) equal to the progress and returns y(t), both in
// signed Q.16. A transaction is accepted at a clock edge where start is high
// and busy is low; busy then stays high until the result has been produced.
// The result appears on eased_value for exactly one cycle, marked by
// result_valid, and the receiver cannot stall it, so it must be captured in
// that cycle. One item is processed at a time. Progress at or below zero, at
// or above one, and the identity curve go straight to the final state. Otherwise
// the time is set by the shared multiplier and the one-bit-per-cycle divider:
// each Newton iteration is a Horner evaluation of x, an evaluation of the
// derivative and a 26-bit division, for up to six iterations; a fallback to
// bisection adds up to 16 steps, and a final Horner evaluation of y follows.
// Configuration is written through cfg_valid/cfg_ready with a register index
// (0: ctrl1_x, 1: ctrl1_y, 2: ctrl2_x, 3: ctrl2_y) and should only be written
// while the block is idle.
module cubic_bezier_easing_eval
    import cbe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic signed [PINW-1:0] progress_in,
    output logic                  result_valid,
    output logic signed [OW-1:0]  eased_value,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [YW-1:0]         cfg_data
);

    logic [XW-1:0]        ctrl1_x_reg, ctrl2_x_reg;
    logic signed [YW-1:0] ctrl1_y_reg, ctrl2_y_reg;
    cmd_t                 cmd;
    status_t              status;

    // The register file is always able to take a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_x_reg <= XW'(16384);
            ctrl1_y_reg <= YW'(6554);
            ctrl2_x_reg <= XW'(16384);
            ctrl2_y_reg <= YW'(65536);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_CTRL1_X: ctrl1_x_reg <= cfg_data[XW-1:0];
                REG_CTRL1_Y: ctrl1_y_reg <= cfg_data;
                REG_CTRL2_X: ctrl2_x_reg <= cfg_data[XW-1:0];
                REG_CTRL2_Y: ctrl2_y_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    cbe_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    cbe_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .progress_in  (progress_in),
        .ctrl1_x      (ctrl1_x_reg),
        .ctrl1_y      (ctrl1_y_reg),
        .ctrl2_x      (ctrl2_x_reg),
        .ctrl2_y      (ctrl2_y_reg),
        .status       (status),
        .result_valid (result_valid),
        .eased_value  (eased_value)
    );

endmodule
